// ----- rtl/rc4o_pkg.sv -----
// rc4o_pkg: shared types and constants for the offset-schedule rc4 keystream block
// no dependencies; used by every other file of the block
`default_nettype none

package rc4o_pkg;

  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned KEY_LOW_W  = 64;
  localparam int unsigned KEY_HIGH_W = 24;
  localparam int unsigned KEY_W      = KEY_LOW_W + KEY_HIGH_W;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 64;

  // register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_LOW    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_HIGH   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KSA_OFFSET = 2'd2;

  localparam logic [BYTE_W-1:0] KSA_OFFSET_RST = 8'h57;
  localparam logic [BYTE_W-1:0] LAST_ENTRY     = 8'hff;

  // item mode codes
  localparam logic MODE_REKEY = 1'b0;
  localparam logic MODE_DATA  = 1'b1;

  typedef logic [BYTE_W-1:0] byte_t;

  // one cycle of access to the permutation memory
  typedef struct packed {
    logic  we;
    byte_t waddr;
    byte_t wdata;
    byte_t raddr;
  } mem_req_t;

endpackage

`default_nettype wire

// ----- rtl/rc4o_if.sv -----
// rc4o_if: valid/ready channel interfaces for input items and result items
// depends on rc4o_pkg
`default_nettype none

interface rc4o_in_if;
  logic            valid;
  logic            ready;
  logic            mode;
  rc4o_pkg::byte_t data_byte;

  modport source (output valid, output mode, output data_byte, input ready);
  modport sink   (input valid, input mode, input data_byte, output ready);
endinterface

interface rc4o_out_if;
  logic            valid;
  logic            ready;
  rc4o_pkg::byte_t out_byte;

  modport source (output valid, output out_byte, input ready);
  modport sink   (input valid, input out_byte, output ready);
endinterface

`default_nettype wire

// ----- rtl/rc4o_perm_ram.sv -----
// rc4o_perm_ram: 256 x 8 permutation memory, one write and one read port
// read data registered, old data returned on same-address write; uses rc4o_pkg
`default_nettype none

module rc4o_perm_ram (
  input  wire                 clk,
  input  rc4o_pkg::mem_req_t  req,
  output rc4o_pkg::byte_t     rd_data
);

  rc4o_pkg::byte_t mem [256];
  rc4o_pkg::byte_t rd_data_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rd_data_r <= mem[req.raddr];
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

// ----- rtl/rc4o_ctrl.sv -----
// rc4o_ctrl: sequencer for key schedule and keystream, result register
// depends on rc4o_pkg, rc4o_if; drives rc4o_perm_ram through a mem_req_t
`default_nettype none

module rc4o_ctrl #(
  parameter int unsigned KEY_BYTES = 11
) (
  input  wire                            clk,
  input  wire                            rst_n,
  rc4o_in_if.sink                        in_ch,
  rc4o_out_if.source                     out_ch,
  input  wire [rc4o_pkg::KEY_W-1:0]      key_i,
  input  rc4o_pkg::byte_t                ksa_offset_i,
  output rc4o_pkg::mem_req_t             req_o,
  input  rc4o_pkg::byte_t                rd_data_i
);

  localparam int unsigned KIDX_W = (KEY_BYTES > 1) ? $clog2(KEY_BYTES) : 1;
  localparam logic [KIDX_W-1:0] KIDX_LAST = KIDX_W'(KEY_BYTES - 1);

  typedef enum logic [3:0] {
    S_IDLE, S_INIT, S_K_RDK, S_K_RDM, S_K_WR1, S_K_WR2,
    S_D_RDJ, S_D_WR1, S_D_WR2, S_D_OUT
  } state_t;

  state_t             state_r, state_nxt;
  rc4o_pkg::byte_t    step_r, step_nxt;   // i, or k during the schedule
  rc4o_pkg::byte_t    mix_r, mix_nxt;     // j, or schedule mix
  rc4o_pkg::byte_t    pi_r, pi_nxt;
  rc4o_pkg::byte_t    pj_r, pj_nxt;
  rc4o_pkg::byte_t    t_r, t_nxt;
  rc4o_pkg::byte_t    data_r, data_nxt;
  rc4o_pkg::byte_t    hold_r, hold_nxt;
  logic [KIDX_W-1:0]  kidx_r, kidx_nxt;
  logic               out_valid_r, out_valid_nxt;
  rc4o_pkg::byte_t    out_byte_r, out_byte_nxt;

  rc4o_pkg::byte_t    key_byte;
  rc4o_pkg::byte_t    ks;
  rc4o_pkg::mem_req_t req;
  logic               in_fire;

  assign key_byte = key_i[8*kidx_r +: 8];
  assign in_fire  = in_ch.valid && in_ch.ready;

  // entries i and j were swapped after the ks read was issued
  always_comb begin
    if (t_r == mix_r) begin
      ks = pi_r;
    end else if (t_r == step_r) begin
      ks = pj_r;
    end else begin
      ks = rd_data_i;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    mix_nxt       = mix_r;
    pi_nxt        = pi_r;
    pj_nxt        = pj_r;
    t_nxt         = t_r;
    data_nxt      = data_r;
    hold_nxt      = hold_r;
    kidx_nxt      = kidx_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_byte_nxt  = out_byte_r;
    req.we        = 1'b0;
    req.waddr     = step_r;
    req.wdata     = step_r;
    req.raddr     = step_r + 8'd1;

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          if (in_ch.mode == rc4o_pkg::MODE_DATA) begin
            step_nxt  = step_r + 8'd1;
            data_nxt  = in_ch.data_byte;
            state_nxt = S_D_RDJ;
          end else begin
            step_nxt  = '0;
            mix_nxt   = '0;
            kidx_nxt  = '0;
            state_nxt = S_INIT;
          end
        end
      end
      S_INIT: begin
        // identity fill
        req.we   = 1'b1;
        step_nxt = step_r + 8'd1;
        if (step_r == rc4o_pkg::LAST_ENTRY) begin
          state_nxt = S_K_RDK;
        end
      end
      S_K_RDK: begin
        req.raddr = step_r;
        state_nxt = S_K_RDM;
      end
      S_K_RDM: begin
        pi_nxt    = rd_data_i;
        mix_nxt   = mix_r + rd_data_i + key_byte + ksa_offset_i;
        req.raddr = mix_nxt;
        state_nxt = S_K_WR1;
      end
      S_K_WR1: begin
        req.we    = 1'b1;
        req.wdata = rd_data_i;
        state_nxt = S_K_WR2;
      end
      S_K_WR2: begin
        req.we    = 1'b1;
        req.waddr = mix_r;
        req.wdata = pi_r;
        step_nxt  = step_r + 8'd1;
        kidx_nxt  = (kidx_r == KIDX_LAST) ? '0 : kidx_r + 1'b1;
        if (step_r == rc4o_pkg::LAST_ENTRY) begin
          mix_nxt   = '0;
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_K_RDK;
        end
      end
      S_D_RDJ: begin
        pi_nxt    = rd_data_i;
        mix_nxt   = mix_r + rd_data_i;
        req.raddr = mix_nxt;
        state_nxt = S_D_WR1;
      end
      S_D_WR1: begin
        pj_nxt    = rd_data_i;
        req.we    = 1'b1;
        req.wdata = rd_data_i;
        t_nxt     = pi_r + rd_data_i;
        req.raddr = t_nxt;
        state_nxt = S_D_WR2;
      end
      S_D_WR2: begin
        req.we    = 1'b1;
        req.waddr = mix_r;
        req.wdata = pi_r;
        hold_nxt  = data_r ^ ks;
        state_nxt = S_D_OUT;
      end
      S_D_OUT: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_byte_nxt  = hold_r;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_r      <= '0;
      mix_r       <= '0;
      kidx_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      mix_r       <= mix_nxt;
      kidx_r      <= kidx_nxt;
      out_valid_r <= out_valid_nxt;
    end
    pi_r       <= pi_nxt;
    pj_r       <= pj_nxt;
    t_r        <= t_nxt;
    data_r     <= data_nxt;
    hold_r     <= hold_nxt;
    out_byte_r <= out_byte_nxt;
  end

  assign in_ch.ready     = (state_r == S_IDLE);
  assign out_ch.valid    = out_valid_r;
  assign out_ch.out_byte = out_byte_r;
  assign req_o           = req;

  a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE || state_r == S_D_OUT) |-> !req.we)
    else $error("memory write outside an active sequence");

  a_init_identity: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_INIT) |-> (req.we && req.waddr == step_r && req.wdata == step_r))
    else $error("identity fill writes wrong entry");

  a_rekey_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_K_WR2 && step_r == rc4o_pkg::LAST_ENTRY) |=>
      (step_r == '0 && mix_r == '0 && state_r == S_IDLE))
    else $error("counters not cleared after key schedule");

  a_out_from_seq: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_D_OUT))
    else $error("result raised outside the output step");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_D_OUT && out_valid_r && !out_ch.ready) |=> (state_r == S_D_OUT))
    else $error("result overwritten while stalled");

endmodule

`default_nettype wire

// ----- rtl/rc4_offset_keystream_cipher.sv -----
// rc4_offset_keystream_cipher: top level, configuration registers and wiring
// depends on rc4o_pkg, rc4o_if, rc4o_perm_ram, rc4o_ctrl
`default_nettype none

// channel   dir   payload                      handshake
// in_ch     in    mode, data_byte              valid/ready
// out_ch    out   out_byte                     valid/ready
// cfg_*     in    cfg_idx, cfg_wdata (64 bit)  cfg_we, no stall
//
// a data item passes S_D_RDJ, S_D_WR1 and S_D_WR2 and enters the output register in
// S_D_OUT once that register is free; no new item is taken until the block is idle;
// the permutation memory has one read and one write port, so the swap needs two writes
// a rekey item fills all 256 entries with their own index, then runs 256 schedule
// steps, each through S_K_RDK, S_K_RDM, S_K_WR1 and S_K_WR2, and gives no result
// a waiting result stalls only the finish of the next data item, never a rekey;
// reset clears counters, state and result flag; permutation unset until first rekey

module rc4_offset_keystream_cipher #(
  parameter int unsigned KEY_BYTES = 11
) (
  input  wire                                 clk,
  input  wire                                 rst_n,
  rc4o_in_if.sink                             in_ch,
  rc4o_out_if.source                          out_ch,
  input  wire                                 cfg_we,
  input  wire [rc4o_pkg::CFG_IDX_W-1:0]       cfg_idx,
  input  wire [rc4o_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

  // configuration registers
  logic [rc4o_pkg::KEY_LOW_W-1:0]  key_low_r;
  logic [rc4o_pkg::KEY_HIGH_W-1:0] key_high_r;
  rc4o_pkg::byte_t                 ksa_offset_r;

  rc4o_pkg::mem_req_t mem_req;
  rc4o_pkg::byte_t    mem_rd_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_low_r    <= '0;
      key_high_r   <= '0;
      ksa_offset_r <= rc4o_pkg::KSA_OFFSET_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        rc4o_pkg::CFG_KEY_LOW:    key_low_r    <= cfg_wdata;
        rc4o_pkg::CFG_KEY_HIGH:   key_high_r   <= cfg_wdata[rc4o_pkg::KEY_HIGH_W-1:0];
        rc4o_pkg::CFG_KSA_OFFSET: ksa_offset_r <= cfg_wdata[rc4o_pkg::BYTE_W-1:0];
        default: ;  // unused index, write dropped
      endcase
    end
  end

  // sequencer: key schedule and keystream generation
  rc4o_ctrl #(
    .KEY_BYTES (KEY_BYTES)
  ) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_ch        (in_ch),
    .out_ch       (out_ch),
    .key_i        ({key_high_r, key_low_r}),
    .ksa_offset_i (ksa_offset_r),
    .req_o        (mem_req),
    .rd_data_i    (mem_rd_data)
  );

  // permutation state
  rc4o_perm_ram u_perm_ram (
    .clk     (clk),
    .req     (mem_req),
    .rd_data (mem_rd_data)
  );

endmodule

`default_nettype wire
